>>> rtl/nearest_neighbor_tx_power_control_core_assert.svh
// Assertion macros for the transmit power control core
`ifndef NEAREST_NEIGHBOR_TX_POWER_CONTROL_CORE_ASSERT_SVH
`define NEAREST_NEIGHBOR_TX_POWER_CONTROL_CORE_ASSERT_SVH
// implication checked every clock outside reset
`define NNTPC_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define NNTPC_ASSERT_NXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

>>> rtl/nntpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nntpc_pkg
// Shared types and constants of the transmit power control core.
// ----------------------------------------------------------------------------
package nntpc_pkg;
  localparam int NEIGHBORS = 16;
  localparam int SLOT_W = $clog2(NEIGHBORS);
  localparam int CNT_W = 5;
  localparam logic [16:0] DB_PER_LOG2_Q16 = 17'd98642;

  localparam logic [2:0] REG_SELF_X   = 3'd0;
  localparam logic [2:0] REG_SELF_Y   = 3'd1;
  localparam logic [2:0] REG_REF_DIST = 3'd2;
  localparam logic [2:0] REG_REF_LOSS = 3'd3;
  localparam logic [2:0] REG_PATH_EXP = 3'd4;
  localparam logic [2:0] REG_TARGET   = 3'd5;
  localparam logic [2:0] REG_TX_MIN   = 3'd6;
  localparam logic [2:0] REG_TX_MAX   = 3'd7;

  localparam logic FUNC_LEARN = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic        func;
    logic [3:0]  slot;
    logic [31:0] x;
    logic [31:0] y;
  } cmd_t;
endpackage

>>> rtl/nntpc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nntpc_queue
// Two-entry command queue between the front end and the executor.
// ----------------------------------------------------------------------------
module nntpc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  nntpc_pkg::cmd_t push_word,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output nntpc_pkg::cmd_t head
);
  nntpc_pkg::cmd_t mem [2];
  logic       wptr, rptr;
  logic [1:0] cnt;

  assign full = (cnt == 2'd2);
  assign not_empty = (cnt != 2'd0);
  assign head = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_word;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

>>> rtl/nntpc_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nntpc_exec
// Back end: neighbor table, nearest search, log2 and power mapping.
// ----------------------------------------------------------------------------
module nntpc_exec (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  nntpc_pkg::cmd_t     cmd,
  output logic                cmd_pop,
  output logic                idle,
  input  logic signed [31:0]  self_x_e6,
  input  logic signed [31:0]  self_y_e6,
  input  logic [30:0]         ref_dist_e6,
  input  logic [15:0]         ref_loss_q8,
  input  logic [10:0]         path_exponent_q8,
  input  logic signed [15:0]  link_target_q8,
  input  logic signed [5:0]   tx_min_dbm,
  input  logic signed [5:0]   tx_max_dbm,
  output logic                done,
  output logic signed [5:0]   tx_power_dbm,
  output logic [5:0]          tx_power_code,
  output logic [4:0]          neighbor_count,
  output logic                used_fallback
);
  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_DIFF, S_SQ, S_CMP, S_RSQ, S_NORM, S_LOG, S_DELTA,
    S_MUL1, S_MUL2, S_SUM, S_OUT
  } state_t;

  state_t state;
  logic [nntpc_pkg::NEIGHBORS-1:0] valid;
  logic [nntpc_pkg::SLOT_W-1:0] idx;
  logic [nntpc_pkg::SLOT_W:0]   walk;
  logic [4:0]  cnt;
  logic        have, rdv, which;
  logic [31:0] ax, ay;
  logic [66:0] sqd, best;
  logic [65:0] r2;
  logic [31:0] mant;
  logic [6:0]  ipart;
  logic [15:0] frac;
  logic [4:0]  step;
  logic [22:0] ld;
  logic [22:0] delta;
  logic [33:0] prod1;
  logic [66:0] prod2;
  logic signed [19:0] q;

  logic [31:0] rdx, rdy;
  logic rd_en;
  logic wr_en;

  assign wr_en = (state == S_IDLE) && cmd_valid && (cmd.func == nntpc_pkg::FUNC_LEARN);
  assign rd_en = 1'b1;

  nntpc_ram #(.WIDTH(32), .DEPTH(nntpc_pkg::NEIGHBORS)) u_xram (
    .clk(clk), .we(wr_en), .waddr(cmd.slot[nntpc_pkg::SLOT_W-1:0]), .wdata(cmd.x),
    .re(rd_en), .raddr(idx), .rdata(rdx));
  nntpc_ram #(.WIDTH(32), .DEPTH(nntpc_pkg::NEIGHBORS)) u_yram (
    .clk(clk), .we(wr_en), .waddr(cmd.slot[nntpc_pkg::SLOT_W-1:0]), .wdata(cmd.y),
    .re(rd_en), .raddr(idx), .rdata(rdy));

  assign cmd_pop = (state == S_IDLE) && cmd_valid;
  assign idle = (state == S_IDLE) && !cmd_valid;

  logic [32:0] dxs, dys;
  logic [31:0] mnorm_src;
  logic [63:0] msq;
  logic [6:0] lz_pos;
  logic [66:0] lsrc;
  logic signed [21:0] qsum;
  logic signed [21:0] lo_lim, hi_lim;
  logic signed [13:0] pr;
  logic [19:0] qa;

  always_comb begin
    dxs = {self_x_e6[31], self_x_e6} - {rdx[31], rdx};
    dys = {self_y_e6[31], self_y_e6} - {rdy[31], rdy};
    lsrc = which ? {1'b0, r2} : best;
    lz_pos = 7'd0;
    for (int i = 0; i < 66; i++) begin
      if (lsrc[i]) lz_pos = 7'(i);
    end
    mnorm_src = (lz_pos >= 7'd31) ? 32'(lsrc >> (lz_pos - 7'd31))
                                  : 32'(lsrc << (7'd31 - lz_pos));
    msq = 64'(mant) * 64'(mant);
    qsum = 22'(link_target_q8) + 22'($signed({1'b0, ref_loss_q8}))
         + 22'($signed({1'b0, prod2[66:32]}));
    lo_lim = 22'(tx_min_dbm) * 22'sd256;
    hi_lim = 22'(tx_max_dbm) * 22'sd256;
    qa = q[19] ? 20'(-q) : q;
    pr = q[19] ? -14'((qa + 20'd128) >> 8) : 14'((qa + 20'd128) >> 8);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd.func == nntpc_pkg::FUNC_LEARN) begin
              valid[cmd.slot[nntpc_pkg::SLOT_W-1:0]] <= 1'b1;
            end else begin
              state <= S_READ;
              idx <= '0;
              walk <= '0;
              cnt <= '0;
              have <= 1'b0;
            end
          end
        end
        S_READ: begin
          rdv <= valid[idx];
          state <= S_DIFF;
        end
        S_DIFF: begin
          ax <= dxs[32] ? 32'(-dxs) : dxs[31:0];
          ay <= dys[32] ? 32'(-dys) : dys[31:0];
          state <= S_SQ;
        end
        S_SQ: begin
          sqd <= {1'b0, 66'(65'(64'(ax) * 64'(ax)) + 65'(64'(ay) * 64'(ay)))};
          state <= S_CMP;
        end
        S_CMP: begin
          if (rdv) begin
            cnt <= cnt + 5'd1;
            if (!have || sqd < best) best <= sqd;
            have <= 1'b1;
          end
          walk <= walk + 1'b1;
          idx <= idx + 1'b1;
          if (walk == (nntpc_pkg::SLOT_W+1)'(nntpc_pkg::NEIGHBORS - 1)) begin
            state <= S_RSQ;
          end else begin
            state <= S_READ;
          end
        end
        S_RSQ: begin
          r2 <= 66'(((ref_dist_e6 == 31'd0) ? 62'd1 : 62'(ref_dist_e6) * 62'(ref_dist_e6)));
          if (!have || best == 67'd0) begin
            tx_power_dbm <= tx_max_dbm;
            tx_power_code <= tx_max_dbm;
            used_fallback <= 1'b1;
            neighbor_count <= cnt;
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            which <= 1'b0;
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (!which && best <= {1'b0, r2}) begin
            prod2 <= '0;
            state <= S_SUM;
          end else begin
            mant <= mnorm_src;
            ipart <= lz_pos;
            frac <= '0;
            step <= '0;
            state <= S_LOG;
          end
        end
        S_LOG: begin
          if (msq[63]) begin
            mant <= msq[63:32];
            frac <= {frac[14:0], 1'b1};
          end else begin
            mant <= msq[62:31];
            frac <= {frac[14:0], 1'b0};
          end
          step <= step + 5'd1;
          if (step == 5'd15) state <= S_DELTA;
        end
        S_DELTA: begin
          if (!which) begin
            ld <= {ipart, frac};
            which <= 1'b1;
            state <= S_NORM;
          end else begin
            delta <= (ld > {ipart, frac}) ? ld - {ipart, frac} : 23'd0;
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          prod1 <= 34'(delta) * 34'(path_exponent_q8);
          state <= S_MUL2;
        end
        S_MUL2: begin
          prod2 <= 67'(prod1) * 67'(nntpc_pkg::DB_PER_LOG2_Q16) + 67'h8000_0000;
          state <= S_SUM;
        end
        S_SUM: begin
          if (qsum < lo_lim) q <= (lo_lim > hi_lim) ? 20'(hi_lim) : 20'(lo_lim);
          else if (qsum > hi_lim) q <= 20'(hi_lim);
          else q <= 20'(qsum);
          state <= S_OUT;
        end
        S_OUT: begin
          tx_power_dbm <= pr[5:0];
          tx_power_code <= pr[5:0];
          used_fallback <= 1'b0;
          neighbor_count <= cnt;
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/nntpc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nntpc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nntpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

>>> rtl/nearest_neighbor_tx_power_control_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_tx_power_control_core
// Neighbor table with nearest-distance transmit power selection.
// ----------------------------------------------------------------------------
// A learn word that reaches the idle executor is popped and written into
// the neighbor table. A query walks all sixteen slots through the read,
// difference, square and compare states, then runs two sixteen-step log2
// iterations, unless the fallback applies or the nearest neighbor lies
// within the reference distance, in which case the log2 stage is skipped.
// Words are queued two deep ahead of the executor; busy is high while the
// queue is full. The receiver cannot stall: done marks each result for one
// cycle, and the result ports hold it until the next result.
module nearest_neighbor_tx_power_control_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               func,
  input  logic [3:0]         neighbor_slot,
  input  logic signed [31:0] coord_x_e6,
  input  logic signed [31:0] coord_y_e6,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               done,
  output logic signed [5:0]  tx_power_dbm,
  output logic [5:0]         tx_power_code,
  output logic [4:0]         neighbor_count,
  output logic               used_fallback
);
  `include "nearest_neighbor_tx_power_control_core_assert.svh"

  logic signed [31:0] self_x_e6, self_y_e6;
  logic [30:0] ref_dist_e6;
  logic [15:0] ref_loss_q8;
  logic [10:0] path_exponent_q8;
  logic signed [15:0] link_target_q8;
  logic signed [5:0] tx_min_dbm, tx_max_dbm;

  nntpc_pkg::cmd_t push_word, head;
  logic q_full, q_ne, pop, eidle, push;

  assign cfg_ready = 1'b1;
  assign busy = q_full;
  assign push = start && !busy
             && !(func == nntpc_pkg::FUNC_LEARN && neighbor_slot >= 4'(nntpc_pkg::NEIGHBORS - 1) + 4'd1
                  && nntpc_pkg::NEIGHBORS < 16);
  assign push_word = '{func: func, slot: neighbor_slot, x: coord_x_e6, y: coord_y_e6};

  always_ff @(posedge clk) begin
    if (rst) begin
      self_x_e6 <= '0;
      self_y_e6 <= '0;
      ref_dist_e6 <= 31'd1000000;
      ref_loss_q8 <= 16'd10253;
      path_exponent_q8 <= 11'd691;
      link_target_q8 <= -16'sd23552;
      tx_min_dbm <= -6'sd32;
      tx_max_dbm <= 6'sd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        nntpc_pkg::REG_SELF_X:   self_x_e6 <= cfg_data;
        nntpc_pkg::REG_SELF_Y:   self_y_e6 <= cfg_data;
        nntpc_pkg::REG_REF_DIST: ref_dist_e6 <= cfg_data[30:0];
        nntpc_pkg::REG_REF_LOSS: ref_loss_q8 <= cfg_data[15:0];
        nntpc_pkg::REG_PATH_EXP: path_exponent_q8 <= cfg_data[10:0];
        nntpc_pkg::REG_TARGET:   link_target_q8 <= cfg_data[15:0];
        nntpc_pkg::REG_TX_MIN:   tx_min_dbm <= cfg_data[5:0];
        nntpc_pkg::REG_TX_MAX:   tx_max_dbm <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  nntpc_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_word(push_word), .pop(pop),
    .full(q_full), .not_empty(q_ne), .head(head));

  nntpc_exec u_exec (
    .clk(clk), .rst(rst), .cmd_valid(q_ne), .cmd(head), .cmd_pop(pop), .idle(eidle),
    .self_x_e6(self_x_e6), .self_y_e6(self_y_e6), .ref_dist_e6(ref_dist_e6),
    .ref_loss_q8(ref_loss_q8), .path_exponent_q8(path_exponent_q8),
    .link_target_q8(link_target_q8), .tx_min_dbm(tx_min_dbm), .tx_max_dbm(tx_max_dbm),
    .done(done), .tx_power_dbm(tx_power_dbm), .tx_power_code(tx_power_code),
    .neighbor_count(neighbor_count), .used_fallback(used_fallback));

  `NNTPC_ASSERT_IMP(a_code_match, done, tx_power_code == tx_power_dbm)
  `NNTPC_ASSERT_IMP(a_idle_empty, eidle, !q_ne)
  `NNTPC_ASSERT_NXT(a_done_pulse, done, !done)
endmodule

>>> sim/nearest_neighbor_tx_power_control_core_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_tx_power_control_core_chk
// Watches the command, register and result channels of the power control
// core. It keeps its own neighbor table and register copy, predicts each
// query's power word and compares every result field by field, in order.
// ----------------------------------------------------------------------------
module nearest_neighbor_tx_power_control_core_chk (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               func,
  input  logic [3:0]         neighbor_slot,
  input  logic signed [31:0] coord_x_e6,
  input  logic signed [31:0] coord_y_e6,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               done,
  input  logic signed [5:0]  tx_power_dbm,
  input  logic [5:0]         tx_power_code,
  input  logic [4:0]         neighbor_count,
  input  logic               used_fallback,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [5:0] dbm;
    logic [4:0] count;
    logic       fallback;
  } power_word_t;

  power_word_t power_q[$];

  logic signed [31:0] self_x, self_y;
  logic [30:0]        ref_dist;
  logic [15:0]        ref_loss;
  logic [10:0]        path_exp;
  logic signed [15:0] target;
  logic signed [5:0]  tx_min, tx_max;

  logic               tbl_valid [nntpc_pkg::NEIGHBORS];
  logic signed [31:0] tbl_x [nntpc_pkg::NEIGHBORS];
  logic signed [31:0] tbl_y [nntpc_pkg::NEIGHBORS];

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic logic [63:0] mag(input logic signed [31:0] a,
                                      input logic signed [31:0] b);
    longint sa, sb;
    sa = a;
    sb = b;
    return (sa >= sb) ? 64'(sa - sb) : 64'(sb - sa);
  endfunction

  function automatic logic [63:0] log2_q16(input logic hi, input logic [63:0] lo);
    logic [63:0] v, m, frac;
    int p, extra;
    v = lo;
    extra = 0;
    frac = 0;
    if (hi) begin
      v = {1'b1, lo[63:1]};
      extra = 1;
    end
    if (v == 0) return 0;
    p = 0;
    while (p < 63 && (v >> (p + 1)) != 0) p++;
    m = (p >= 31) ? (v >> (p - 31)) : (v << (31 - p));
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return (64'(p + extra) << 16) | frac;
  endfunction

  function automatic power_word_t predict_power();
    power_word_t w;
    logic [63:0] ax, ay, sq, lo, best_lo, rd, r2, ld, lr, delta, loss;
    logic hi, best_hi, have, fb;
    int cnt;
    longint q, lim, p;
    best_lo = 0;
    best_hi = 0;
    have = 0;
    cnt = 0;
    for (int i = 0; i < nntpc_pkg::NEIGHBORS; i++) begin
      if (tbl_valid[i]) begin
        cnt++;
        ax = mag(self_x, tbl_x[i]);
        ay = mag(self_y, tbl_y[i]);
        sq = ax * ax;
        lo = sq + ay * ay;
        hi = lo < sq;
        if (!have || (hi < best_hi) || (hi == best_hi && lo < best_lo)) begin
          best_hi = hi;
          best_lo = lo;
          have = 1;
        end
      end
    end
    fb = !have || (!best_hi && best_lo == 0);
    if (fb) begin
      p = tx_max;
    end else begin
      rd = (ref_dist == 0) ? 64'd1 : 64'(ref_dist);
      r2 = rd * rd;
      loss = 0;
      if (best_hi || best_lo > r2) begin
        ld = log2_q16(best_hi, best_lo);
        lr = log2_q16(1'b0, r2);
        delta = (ld > lr) ? ld - lr : 64'd0;
        loss = (delta * 64'(path_exp) * 64'(nntpc_pkg::DB_PER_LOG2_Q16)
                + 64'h8000_0000) >> 32;
      end
      q = longint'(target) + longint'(ref_loss) + longint'(loss);
      lim = longint'(tx_min) * 256;
      if (q < lim) q = lim;
      lim = longint'(tx_max) * 256;
      if (q > lim) q = lim;
      if (q >= 0) p = (q + 128) / 256;
      else p = -((-q + 128) / 256);
    end
    if (p < -32) p = -32;
    if (p > 31) p = 31;
    w.dbm = p[5:0];
    w.count = (cnt > 31) ? 5'd31 : cnt[4:0];
    w.fallback = fb;
    return w;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
    self_x = 0;
    self_y = 0;
    ref_dist = 31'd1000000;
    ref_loss = 16'd10253;
    path_exp = 11'd691;
    target = -16'sd23552;
    tx_min = -6'sd32;
    tx_max = 6'sd0;
    for (int i = 0; i < nntpc_pkg::NEIGHBORS; i++) tbl_valid[i] = 1'b0;
  end

  always @(posedge clk) begin
    power_word_t w;
    if (!rst) begin
      if (done) begin
        if (power_q.size() == 0) begin
          report("result with none expected", 1, 0);
        end else begin
          w = power_q.pop_front();
          if (tx_power_dbm !== w.dbm)
            report("tx_power_dbm", tx_power_dbm, $signed(w.dbm));
          if (tx_power_code !== w.dbm)
            report("tx_power_code", tx_power_code, w.dbm);
          if (neighbor_count !== w.count)
            report("neighbor_count", neighbor_count, w.count);
          if (used_fallback !== w.fallback)
            report("used_fallback", used_fallback, w.fallback);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          nntpc_pkg::REG_SELF_X:   self_x = cfg_data;
          nntpc_pkg::REG_SELF_Y:   self_y = cfg_data;
          nntpc_pkg::REG_REF_DIST: ref_dist = cfg_data[30:0];
          nntpc_pkg::REG_REF_LOSS: ref_loss = cfg_data[15:0];
          nntpc_pkg::REG_PATH_EXP: path_exp = cfg_data[10:0];
          nntpc_pkg::REG_TARGET:   target = cfg_data[15:0];
          nntpc_pkg::REG_TX_MIN:   tx_min = cfg_data[5:0];
          nntpc_pkg::REG_TX_MAX:   tx_max = cfg_data[5:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (func == nntpc_pkg::FUNC_LEARN) begin
          if (neighbor_slot < nntpc_pkg::NEIGHBORS) begin
            tbl_x[neighbor_slot] = coord_x_e6;
            tbl_y[neighbor_slot] = coord_y_e6;
            tbl_valid[neighbor_slot] = 1'b1;
          end
        end else begin
          power_q = {power_q, predict_power()};
        end
      end
      pending = power_q.size();
    end
  end

endmodule

>>> sim/nearest_neighbor_tx_power_control_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_tx_power_control_core_tb
// Drives learn and query words and register settings into the power control
// core: a directed opening, then random phases with varied registers and
// sender gaps. The checker beside the core predicts and compares results.
// ----------------------------------------------------------------------------
module nearest_neighbor_tx_power_control_core_tb;

  localparam int DRAIN_CYCLES = 400;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               func;
  logic [3:0]         neighbor_slot;
  logic signed [31:0] coord_x_e6;
  logic signed [31:0] coord_y_e6;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               done;
  logic signed [5:0]  tx_power_dbm;
  logic [5:0]         tx_power_code;
  logic [4:0]         neighbor_count;
  logic               used_fallback;
  int                 fail_count;
  int                 pending;
  int                 gap_pct;
  logic signed [31:0] own_x, own_y;

  nearest_neighbor_tx_power_control_core dut (.*);
  nearest_neighbor_tx_power_control_core_chk chk (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic send_word(input logic f, input int s,
                           input logic [31:0] x, input logic [31:0] y);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    func <= f;
    neighbor_slot <= s[3:0];
    coord_x_e6 <= x;
    coord_y_e6 <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_regs(input int kind);
    logic [31:0] v [8];
    case (kind)
      0: v = '{0, 0, 1000000, 10253, 691, 32'hffffa400, 32'h20, 0};
      1: v = '{32'h80000000, 32'h80000000, 0, 0, 0, 32'hffff8000, 32'h20, 32'h20};
      2: v = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'hffff, 32'h7ff,
               32'h7fff, 32'h1f, 32'h1f};
      3: v = '{$urandom, $urandom, $urandom_range(1, 4000000), $urandom_range(0, 20000),
               $urandom_range(200, 1200), $urandom, 32'h1f, 32'h21};
      default: v = '{$urandom_range(0, 20000000) - 10000000,
                     $urandom_range(0, 20000000) - 10000000,
                     $urandom_range(1, 5000000), $urandom_range(0, 65535),
                     $urandom_range(0, 2047), $urandom, $urandom, $urandom};
    endcase
    wait_idle();
    for (int i = 0; i < 8; i++) write_reg(i[2:0], v[i]);
    cfg_valid <= 1'b0;
    own_x = v[0];
    own_y = v[1];
  endtask

  task automatic random_word();
    logic [31:0] x, y;
    int r;
    r = $urandom_range(99);
    if (r < 30) begin
      send_word(nntpc_pkg::FUNC_QUERY, $urandom, $urandom, $urandom);
    end else begin
      if (r < 50) begin
        x = $urandom;
        y = $urandom;
      end else if (r < 55) begin
        x = own_x;
        y = own_y;
      end else begin
        x = own_x + $signed($urandom_range(0, 1 << 23)) - (1 << 22);
        y = own_y + $signed($urandom_range(0, 1 << 23)) - (1 << 22);
      end
      send_word(nntpc_pkg::FUNC_LEARN, $urandom, x, y);
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    func = nntpc_pkg::FUNC_LEARN;
    neighbor_slot = 0;
    coord_x_e6 = 0;
    coord_y_e6 = 0;
    cfg_valid = 1'b0;
    cfg_index = nntpc_pkg::REG_SELF_X;
    cfg_data = 0;
    gap_pct = 0;
    own_x = 0;
    own_y = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    set_regs(0);

    // empty table, zero distance, below reference, far, extremes
    send_word(nntpc_pkg::FUNC_QUERY, 0, 0, 0);
    send_word(nntpc_pkg::FUNC_LEARN, 0, 0, 0);
    send_word(nntpc_pkg::FUNC_QUERY, 0, 0, 0);
    send_word(nntpc_pkg::FUNC_LEARN, 0, 1000, 0);
    send_word(nntpc_pkg::FUNC_QUERY, 0, 0, 0);
    send_word(nntpc_pkg::FUNC_LEARN, 0, 32'h7fffffff, 32'h7fffffff);
    send_word(nntpc_pkg::FUNC_LEARN, 15, 32'h80000000, 32'h80000000);
    send_word(nntpc_pkg::FUNC_QUERY, 15, 32'hffffffff, 32'hffffffff);
    send_word(nntpc_pkg::FUNC_LEARN, 5, 32'h55555555, 32'haaaaaaaa);
    send_word(nntpc_pkg::FUNC_LEARN, 10, 32'haaaaaaaa, 32'h55555555);
    send_word(nntpc_pkg::FUNC_QUERY, 0, 0, 0);
    send_word(nntpc_pkg::FUNC_LEARN, 3, 3000000, 4000000);
    send_word(nntpc_pkg::FUNC_QUERY, 0, 0, 0);
    for (int i = 0; i < nntpc_pkg::NEIGHBORS; i++)
      send_word(nntpc_pkg::FUNC_LEARN, i, 32'h80000000 + i, 32'h7fffffff - i);
    send_word(nntpc_pkg::FUNC_QUERY, 0, 0, 0);
    set_regs(1);
    send_word(nntpc_pkg::FUNC_QUERY, 0, 0, 0);
    send_word(nntpc_pkg::FUNC_LEARN, 2, 32'h80000001, 32'h80000000);
    send_word(nntpc_pkg::FUNC_QUERY, 0, 0, 0);
    set_regs(2);
    send_word(nntpc_pkg::FUNC_QUERY, 0, 0, 0);
    send_word(nntpc_pkg::FUNC_LEARN, 2, 32'h7ffffffe, 32'h7fffff00);
    send_word(nntpc_pkg::FUNC_QUERY, 0, 0, 0);

    // hold the sender until the pipeline is empty
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      set_regs(ph == 0 ? 3 : 4);
      case (ph % 4)
        0: gap_pct = 0;
        1: gap_pct = 55;
        2: gap_pct = 0;
        default: gap_pct = 16;
      endcase
      for (int n = 0; n < 128; n++) random_word();
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("nearest_neighbor_tx_power_control_core_tb OK");
    else
      $display("nearest_neighbor_tx_power_control_core_tb NOT OK");
    $finish;
  end

  initial begin
    #(8 * 1000000);
    $display("nearest_neighbor_tx_power_control_core_tb NOT OK");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/nntpc_pkg.sv
rtl/nntpc_queue.sv
rtl/nntpc_exec.sv
rtl/nntpc_ram.sv
rtl/nearest_neighbor_tx_power_control_core.sv
sim/nearest_neighbor_tx_power_control_core_chk.sv
sim/nearest_neighbor_tx_power_control_core_tb.sv
